@@ rtl/core/sid_pkg.sv @@
// ----------------------------------------------------------------------------
// sid_pkg
// Shared types for the signed integer divider: controller states and the
// command word from the controller to the datapath.
// ----------------------------------------------------------------------------
package sid_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX
  } sid_state_t;

  typedef struct packed {
    logic load;    // capture operands, magnitudes and special-case flags
    logic step;    // one restoring shift-subtract iteration
    logic finish;  // sign fixup, saturation, register the result word
  } sid_cmd_t;

endpackage

@@ rtl/core/sid_ctrl.sv @@
// ----------------------------------------------------------------------------
// sid_ctrl
// Sequencer: accepts a word, runs DATA_WIDTH divide steps and a fixup step,
// then pulses done with the registered result.
// ----------------------------------------------------------------------------
module sid_ctrl #(
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output sid_pkg::sid_cmd_t cmd
);

  localparam int CntW = $clog2(DATA_WIDTH);

  sid_pkg::sid_state_t state, state_next;
  logic [CntW-1:0]     cnt, cnt_next;
  logic                done_next;

  // next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      sid_pkg::ST_IDLE: begin
        if (start) begin
          state_next = sid_pkg::ST_DIV;
          cnt_next   = CntW'(DATA_WIDTH - 1);
        end
      end
      sid_pkg::ST_DIV: begin
        if (cnt == '0) begin
          state_next = sid_pkg::ST_FIX;
        end else begin
          cnt_next = cnt - CntW'(1);
        end
      end
      sid_pkg::ST_FIX: begin
        state_next = sid_pkg::ST_IDLE;
      end
      default: begin
        state_next = sid_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    done_next = 1'b0;
    unique case (state)
      sid_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      sid_pkg::ST_DIV: begin
        cmd.step = 1'b1;
      end
      sid_pkg::ST_FIX: begin
        cmd.finish = 1'b1;
        done_next  = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sid_pkg::ST_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

  a_accept_starts_div: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == sid_pkg::ST_DIV && cnt == CntW'(DATA_WIDTH - 1)))
    else $error("accepted word did not start the divide loop");

  a_last_step_to_fix: assert property (@(posedge clk) disable iff (rst)
    (state == sid_pkg::ST_DIV && cnt == '0) |=> (state == sid_pkg::ST_FIX))
    else $error("divide loop did not end in fixup");

  a_done_after_fix: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy || $past(state) == sid_pkg::ST_FIX))
    else $error("done without a fixup cycle");

endmodule

@@ rtl/core/sid_dp.sv @@
// ----------------------------------------------------------------------------
// sid_dp
// Datapath: operand magnitudes, restoring shift-subtract loop, sign fixup
// and saturation, result registers.
// ----------------------------------------------------------------------------
module sid_dp #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  sid_pkg::sid_cmd_t            cmd,
  input  logic signed [DATA_WIDTH-1:0] dividend_in,
  input  logic signed [DATA_WIDTH-1:0] divisor_in,
  output logic signed [DATA_WIDTH-1:0] quotient,
  output logic                         saturated
);

  localparam logic [DATA_WIDTH-1:0] MaxPos = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MinNeg = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic [DATA_WIDTH-1:0] num;   // dividend bits out, quotient bits in
  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] den;
  logic                  neg;   // quotient sign
  logic                  sat;   // zero divisor or MIN / -1

  logic [DATA_WIDTH-1:0] a_u, b_u;
  logic [DATA_WIDTH:0]   trial;

  assign a_u   = dividend_in;
  assign b_u   = divisor_in;
  assign trial = {rem, num[DATA_WIDTH-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num <= a_u[DATA_WIDTH-1] ? ('0 - a_u) : a_u;
      den <= b_u[DATA_WIDTH-1] ? ('0 - b_u) : b_u;
      rem <= '0;
      neg <= a_u[DATA_WIDTH-1] ^ b_u[DATA_WIDTH-1];
      sat <= (b_u == '0) || (b_u == '1 && a_u == MinNeg);
    end else if (cmd.step) begin
      if (!trial[DATA_WIDTH]) begin
        rem <= trial[DATA_WIDTH-1:0];
        num <= {num[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem <= {rem[DATA_WIDTH-2:0], num[DATA_WIDTH-1]};
        num <= {num[DATA_WIDTH-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      saturated <= sat;
      if (sat) begin
        quotient <= MaxPos;
      end else begin
        quotient <= neg ? ('0 - num) : num;
      end
    end
  end

  a_sat_value: assert property (@(posedge clk)
    $past(cmd.finish) && saturated |-> quotient == MaxPos)
    else $error("saturated result is not the largest positive value");

endmodule

@@ rtl/core/signed_integer_divider.sv @@
// ----------------------------------------------------------------------------
// signed_integer_divider
// Signed DATA_WIDTH-bit divider, quotient truncated toward zero, restoring
// shift-subtract over the operand magnitudes; saturates on divide by zero
// and on the most negative dividend over -1.
// ----------------------------------------------------------------------------
//
//  channel   handshake      word
//  -------   ------------   ---------------------------------------
//  input     start / busy   dividend_in, divisor_in
//  result    done (pulse)   quotient, saturated
//
//  Operands are loaded in the accept cycle, then one quotient bit per cycle
//  comes through the single shared subtractor, then a sign and saturation
//  fixup step follows. done pulses the cycle after fixup.
//  A new word may be started while done is high; busy is low then.
//  Reset (rst, synchronous) returns the sequencer to idle and clears done.
//  The receiver takes each result in its done cycle and cannot stall.
//
module signed_integer_divider #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] dividend_in,
  input  logic signed [DATA_WIDTH-1:0] divisor_in,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] quotient,
  output logic                         saturated
);

  sid_pkg::sid_cmd_t cmd;

  // sequencer: load on accept, DATA_WIDTH steps, fixup, done pulse
  sid_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // magnitudes, iteration registers and result registers
  sid_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .dividend_in (dividend_in),
    .divisor_in  (divisor_in),
    .quotient    (quotient),
    .saturated   (saturated)
  );

endmodule
